// ----- hw/rtl/lcydm_pkg.sv -----
// Package for the line camera y distortion map: widths, codes and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
package lcydm_pkg;

    localparam int MAX_ITERATIONS = 50;
    localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
    localparam int MUL_STEPS      = 8;
    localparam int DIV_STEPS      = 55;
    localparam int CNT_W          = 6;

    localparam int COEF_W = 48;
    localparam int TOL_W  = 21;
    localparam int LIM_W  = 55;
    localparam int Q_W    = 56;
    localparam int CFG_W  = 55;

    localparam logic [1:0] CFG_COEF = 2'd0;
    localparam logic [1:0] CFG_TOL  = 2'd1;
    localparam logic [1:0] CFG_LIM  = 2'd2;

    localparam logic [55:0] PLACEHOLDER_Y = 56'd109951162777600;
    localparam logic [78:0] ONE_Q40       = 79'd1 << 40;
    localparam logic [55:0] POS_LIM       = 56'h7F_FFFF_FFFF_FFFF;
    localparam logic [55:0] NEG_LIM       = 56'h80_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOB   = 2'd1,
        ST_NCONV = 2'd2,
        ST_ZDEN  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_KM,
        MUL_FW
    } t_mul_sel;

    typedef enum logic [1:0] {
        RES_FWD,
        RES_OOB,
        RES_FAIL,
        RES_CONV
    } t_res;

    typedef struct packed {
        logic     load;
        logic     mul_init;
        t_mul_sel mul_sel;
        logic     mul_step;
        logic     den_calc;
        logic     div_init;
        logic     div_step;
        logic     upd;
        logic     set_res;
        t_res     res;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic oob;
        logic den_zero;
        logic den_big;
        logic div_ovf;
        logic conv;
    } t_stat;

endpackage

// ----- hw/rtl/lcydm_dp.sv -----
// Datapath of the line camera y distortion map: configuration registers,
// an 8-bit-per-cycle multiplier, a bit-serial divider and the result registers.
// Depends on lcydm_pkg.
module lcydm_dp
    import lcydm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_func,
    input  logic signed [Q_W-1:0] i_x_in,
    input  logic signed [Q_W-1:0] i_y_in,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic signed [Q_W-1:0] o_x_out,
    output logic signed [Q_W-1:0] o_y_out,
    output logic [1:0]          o_status,
    input  logic                i_rst_n
);

    logic [COEF_W-1:0] r_coef;
    logic [TOL_W-1:0]  r_tol;
    logic [LIM_W-1:0]  r_lim;

    logic          r_func;
    logic [55:0]   r_x;
    logic          r_yneg;
    logic [55:0]   r_ymag;
    logic [55:0]   r_tmag;
    logic [54:0]   r_pmag;
    logic          r_pneg;
    logic          r_have_prev;
    logic [135:0]  r_prod;
    logic [71:0]   r_mula;
    logic [78:0]   r_dmag;
    logic          r_dneg;
    logic [78:0]   r_rem;
    logic [54:0]   r_numlo;
    logic [54:0]   r_q;
    logic [55:0]   r_y_res;
    logic [1:0]    r_st;
    logic [55:0]   r_out_x;
    logic [55:0]   r_out_y;
    logic [1:0]    r_out_st;

    function automatic logic [55:0] encode(input logic neg, input logic [55:0] mag);
        encode = neg ? (~mag + 56'd1) : mag;
    endfunction

    logic [71:0]  mul_a;
    logic [63:0]  mul_b;
    logic [79:0]  mul_sum;
    logic [47:0]  kabs;
    logic [78:0]  m_ext;
    logic [78:0]  n_dmag;
    logic         n_dneg;
    logic [79:0]  div_t;
    logic         div_ge;
    logic         tneg;
    logic [55:0]  diff;
    logic [95:0]  fw_r;
    logic         rneg;
    logic [55:0]  lim;
    logic [55:0]  rmag;
    logic [55:0]  ymag_in;

    assign kabs  = r_coef[COEF_W-1] ? (~r_coef + 48'd1) : r_coef;
    assign m_ext = {1'b0, r_prod[117:40]};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_SQ: begin
                mul_a = {16'd0, r_tmag};
                mul_b = {8'd0, r_tmag};
            end
            MUL_KM: begin
                mul_a = {1'b0, r_prod[110:40]};
                mul_b = {16'd0, kabs};
            end
            MUL_FW: begin
                mul_a = {16'd0, r_ymag};
                mul_b = {1'b0, r_dmag[62:0]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_sum = {8'd0, r_prod[135:64]} + 80'(r_mula * r_prod[7:0]);

    always_comb begin
        if (!r_coef[COEF_W-1]) begin
            n_dmag = m_ext + ONE_Q40;
            n_dneg = 1'b0;
        end else if (m_ext <= ONE_Q40) begin
            n_dmag = ONE_Q40 - m_ext;
            n_dneg = 1'b0;
        end else begin
            n_dmag = m_ext - ONE_Q40;
            n_dneg = 1'b1;
        end
    end

    // Restoring division: the remainder always stays below the divisor.
    assign div_t  = {r_rem, r_numlo[54]};
    assign div_ge = div_t >= {1'b0, r_dmag};

    assign tneg = (r_yneg ^ r_dneg) && (r_q != '0);
    always_comb begin
        if (tneg == r_pneg) begin
            diff = (r_q >= r_pmag) ? {1'b0, r_q - r_pmag} : {1'b0, r_pmag - r_q};
        end else begin
            diff = {1'b0, r_q} + {1'b0, r_pmag};
        end
    end

    assign fw_r = r_prod[135:40];
    assign rneg = r_yneg ^ r_dneg;
    assign lim  = rneg ? NEG_LIM : POS_LIM;
    always_comb begin
        if (r_dmag[78:63] != '0) begin
            rmag = (r_ymag == '0) ? '0 : lim;
        end else if (fw_r > {40'd0, lim}) begin
            rmag = lim;
        end else begin
            rmag = fw_r[55:0];
        end
    end

    assign ymag_in = i_y_in[Q_W-1] ? (~i_y_in + 56'd1) : i_y_in;

    assign o_stat.func     = r_func;
    assign o_stat.oob      = r_ymag > {1'b0, r_lim};
    assign o_stat.den_zero = r_dmag == '0;
    assign o_stat.den_big  = r_dmag[78:63] != '0;
    assign o_stat.div_ovf  = {38'd0, r_ymag[55:15]} >= r_dmag;
    assign o_stat.conv     = r_have_prev && (diff <= {35'd0, r_tol});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
            r_tol  <= 21'd110;
            r_lim  <= 55'd43980465111040;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COEF: r_coef <= i_cfg_data[COEF_W-1:0];
                CFG_TOL:  r_tol  <= i_cfg_data[TOL_W-1:0];
                CFG_LIM:  r_lim  <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_func;
            r_x         <= i_x_in;
            r_yneg      <= i_y_in[Q_W-1];
            r_ymag      <= ymag_in;
            r_tmag      <= ymag_in;
            r_have_prev <= 1'b0;
        end
        if (i_cmd.mul_init) begin
            r_prod <= {72'd0, mul_b};
            r_mula <= mul_a;
        end else if (i_cmd.mul_step) begin
            r_prod <= {mul_sum, r_prod[63:8]};
        end
        if (i_cmd.den_calc) begin
            r_dmag <= n_dmag;
            r_dneg <= n_dneg;
        end
        if (i_cmd.div_init) begin
            r_rem   <= {38'd0, r_ymag[55:15]};
            r_numlo <= {r_ymag[14:0], 40'd0};
            r_q     <= '0;
        end else if (i_cmd.div_step) begin
            r_rem   <= div_ge ? 79'(div_t - {1'b0, r_dmag}) : div_t[78:0];
            r_numlo <= {r_numlo[53:0], 1'b0};
            r_q     <= {r_q[53:0], div_ge};
        end
        if (i_cmd.upd) begin
            r_tmag      <= {1'b0, r_q};
            r_pmag      <= r_q;
            r_pneg      <= tneg;
            r_have_prev <= 1'b1;
        end
        if (i_cmd.set_res) begin
            case (i_cmd.res)
                RES_FWD: begin
                    if (r_dmag == '0) begin
                        r_y_res <= '0;
                        r_st    <= ST_ZDEN;
                    end else begin
                        r_y_res <= encode(rneg, rmag);
                        r_st    <= ST_OK;
                    end
                end
                RES_OOB: begin
                    r_y_res <= PLACEHOLDER_Y;
                    r_st    <= ST_OOB;
                end
                RES_CONV: begin
                    r_y_res <= encode(tneg, {1'b0, r_q});
                    r_st    <= ST_OK;
                end
                default: begin
                    r_y_res <= '0;
                    r_st    <= ST_NCONV;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_x  <= r_x;
            r_out_y  <= r_y_res;
            r_out_st <= r_st;
        end
    end

    assign o_x_out  = r_out_x;
    assign o_y_out  = r_out_y;
    assign o_status = r_out_st;

endmodule

// ----- hw/rtl/lcydm_ctrl.sv -----
// Controller of the line camera y distortion map: sequences multiply, divide
// and update steps in the datapath and owns the handshakes.
// Depends on lcydm_pkg.
module lcydm_ctrl
    import lcydm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_SQ, S_SQ_RUN, S_KM, S_KM_RUN, S_DEN, S_BR,
        S_FW, S_FW_RUN, S_FIN, S_DIV_RUN, S_UPD, S_OUT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [ITER_W-1:0] r_iter;
    logic              r_out_valid;
    logic              out_free;

    assign o_stall  = r_state != S_IDLE;
    assign o_valid  = r_out_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_SQ;
        o_cmd.res     = RES_FAIL;
        unique case (r_state)
            S_IDLE: o_cmd.load = i_valid;
            S_CHK: begin
                if (i_stat.func && i_stat.oob) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = RES_OOB;
                end
            end
            S_SQ: begin
                o_cmd.mul_init = 1'b1;
                o_cmd.mul_sel  = MUL_SQ;
            end
            S_KM: begin
                o_cmd.mul_init = 1'b1;
                o_cmd.mul_sel  = MUL_KM;
            end
            S_FW: begin
                o_cmd.mul_init = 1'b1;
                o_cmd.mul_sel  = MUL_FW;
            end
            S_SQ_RUN, S_KM_RUN, S_FW_RUN: o_cmd.mul_step = 1'b1;
            S_DEN: o_cmd.den_calc = 1'b1;
            S_BR: begin
                if (i_stat.func) begin
                    if (i_stat.den_zero || i_stat.div_ovf) begin
                        o_cmd.set_res = 1'b1;
                    end else begin
                        o_cmd.div_init = 1'b1;
                    end
                end
            end
            S_FIN: begin
                o_cmd.set_res = 1'b1;
                o_cmd.res     = RES_FWD;
            end
            S_DIV_RUN: o_cmd.div_step = 1'b1;
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (i_stat.conv) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = RES_CONV;
                end else if (r_iter == ITER_W'(MAX_ITERATIONS - 1)) begin
                    o_cmd.set_res = 1'b1;
                end
            end
            S_OUT: o_cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_CHK;
                S_CHK: begin
                    r_iter  <= '0;
                    r_state <= (i_stat.func && i_stat.oob) ? S_OUT : S_SQ;
                end
                S_SQ, S_KM, S_FW: begin
                    r_cnt   <= '0;
                    r_state <= (r_state == S_SQ) ? S_SQ_RUN
                             : (r_state == S_KM) ? S_KM_RUN : S_FW_RUN;
                end
                S_SQ_RUN, S_KM_RUN, S_FW_RUN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_state <= (r_state == S_SQ_RUN) ? S_KM
                                 : (r_state == S_KM_RUN) ? S_DEN : S_FIN;
                    end
                end
                S_DEN: r_state <= S_BR;
                S_BR: begin
                    r_cnt <= '0;
                    if (!i_stat.func) begin
                        r_state <= (i_stat.den_zero || i_stat.den_big) ? S_FIN : S_FW;
                    end else begin
                        r_state <= (i_stat.den_zero || i_stat.div_ovf) ? S_OUT : S_DIV_RUN;
                    end
                end
                S_FIN: r_state <= S_OUT;
                S_DIV_RUN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) r_state <= S_UPD;
                end
                S_UPD: begin
                    if (i_stat.conv || r_iter == ITER_W'(MAX_ITERATIONS - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_iter  <= r_iter + ITER_W'(1);
                        r_state <= S_SQ;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> r_state == S_CHK)
        else $error("accepted transaction did not start processing");
    a_out_loads_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("result loaded without raising valid");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("pending result overwritten");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter < ITER_W'(MAX_ITERATIONS))
        else $error("iteration counter past budget");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV_RUN |-> r_cnt < CNT_W'(DIV_STEPS))
        else $error("divider step count out of range");
`endif

endmodule

// ----- hw/rtl/line_camera_y_distortion_map.sv -----
// Top level of the line camera y distortion map: joins the controller and
// the datapath. Depends on lcydm_pkg, lcydm_ctrl and lcydm_dp.
//
// Usage: an input transaction (i_func, i_x_in, i_y_in) is taken when i_valid
// is high and o_stall is low; a result transaction (o_x_out, o_y_out,
// o_status) is taken when o_valid is high and i_stall is low. Registers are
// written through i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data
// (0 coefficient, 1 tolerance, 2 bound); write them only while idle.
// One item is processed at a time. Forward mapping runs three multiplies
// (square, coefficient and forward product) on an 8-bit-per-cycle multiplier,
// the last one skipped when the denominator is zero or too large. The inverse
// goes straight to the output when out of bounds, otherwise it runs up to 50
// iterations of two multiplies and a restoring divide. The next input
// is accepted the cycle after the result is loaded.
// A finished result waits in the output register while the next input is
// already accepted; if the receiver keeps stalling, the block stalls its
// input once the next result is ready. Reset restores the register defaults
// and empties the block; no clearing pass is needed.
module line_camera_y_distortion_map
    import lcydm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_func,
    input  logic signed [Q_W-1:0] i_x_in,
    input  logic signed [Q_W-1:0] i_y_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [Q_W-1:0] o_x_out,
    output logic signed [Q_W-1:0] o_y_out,
    output logic [1:0]            o_status,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    lcydm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lcydm_dp u_dp (
        .i_clk       (i_clk),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_func),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_status    (o_status),
        .i_rst_n     (i_rst_n)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for line_camera_y_distortion_map: forward and inverse
// y mapping under several register settings, checked against a local predictor.
// Depends on lcydm_pkg and the line_camera_y_distortion_map RTL.
module tb
    import lcydm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [55:0] ONE_Y = 56'd1 << 40;

    typedef struct packed {
        logic        func;
        logic [55:0] x;
        logic [55:0] y;
    } t_point;

    typedef struct packed {
        logic [55:0] x;
        logic [55:0] y;
        t_status     st;
    } t_mapped;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_func = 1'b0;
    logic signed [Q_W-1:0] i_x_in = '0;
    logic signed [Q_W-1:0] i_y_in = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic signed [Q_W-1:0] o_x_out;
    logic signed [Q_W-1:0] o_y_out;
    logic [1:0]            o_status;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    line_camera_y_distortion_map u_dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Register copies used by the predictor.
    logic [47:0] coef_r = '0;
    logic [20:0] tol_r  = 21'd110;
    logic [54:0] bound_r = 55'd43980465111040;

    t_point  point_q[$];
    t_mapped expected_q[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      results_seen = 0;
    int      status_seen[4];
    bit      quiet = 1'b0;
    int      gap_cnt = 0;
    int      stall_cnt = 0;
    int      idle_cycles = 0;

    // 1 + k*y*y in Q.40 as sign and magnitude, truncated on magnitudes.
    task automatic lens_denominator(input logic [55:0] ymag, output logic dneg,
                                    output logic [127:0] dmag);
        logic [127:0] kabs, yw, rr, m;
        kabs = coef_r[47] ? {80'd0, -coef_r} : {80'd0, coef_r};
        yw = {72'd0, ymag};
        rr = (yw * yw) >> 40;
        m = (kabs * rr) >> 40;
        dneg = 1'b0;
        if (!coef_r[47]) begin
            dmag = m + (128'd1 << 40);
        end else if (m <= (128'd1 << 40)) begin
            dmag = (128'd1 << 40) - m;
        end else begin
            dmag = m - (128'd1 << 40);
            dneg = 1'b1;
        end
    endtask

    function automatic logic [55:0] to_signed56(logic neg, logic [55:0] mag);
        return neg ? (~mag + 56'd1) : mag;
    endfunction

    task automatic map_point(input t_point p, output t_mapped r);
        logic         yneg, dneg, tneg, pneg, have_prev, done;
        logic [55:0]  ymag, tmag, pmag, lim;
        logic [127:0] dmag, num, q, prod, diff;
        yneg = p.y[55];
        ymag = yneg ? -p.y : p.y;
        r.x = p.x;
        r.y = '0;
        r.st = ST_OK;
        if (!p.func) begin
            lens_denominator(ymag, dneg, dmag);
            if (dmag == 0) begin
                r.st = ST_ZDEN;
            end else begin
                lim = (yneg != dneg) ? NEG_LIM : POS_LIM;
                if (dmag >= (128'd1 << 63)) begin
                    tmag = (ymag == 0) ? 56'd0 : lim;
                end else begin
                    prod = ({72'd0, ymag} * dmag) >> 40;
                    tmag = (prod > {72'd0, lim}) ? lim : prod[55:0];
                end
                r.y = to_signed56(yneg != dneg, tmag);
            end
        end else if ({1'b0, ymag} > {2'b0, bound_r}) begin
            r.y = PLACEHOLDER_Y;
            r.st = ST_OOB;
        end else begin
            num = {72'd0, ymag} << 40;
            tmag = ymag;
            pmag = '0;
            pneg = 1'b0;
            have_prev = 1'b0;
            done = 1'b0;
            r.st = ST_NCONV;
            for (int i = 0; i < MAX_ITERATIONS && !done; i++) begin
                lens_denominator(tmag, dneg, dmag);
                if (dmag == 0) break;
                q = num / dmag;
                if (q > {73'd0, POS_LIM[54:0]}) break;
                tmag = q[55:0];
                tneg = (yneg != dneg) && (tmag != 0);
                if (have_prev) begin
                    if (tneg == pneg)
                        diff = (tmag >= pmag) ? tmag - pmag : pmag - tmag;
                    else
                        diff = {72'd0, tmag} + {72'd0, pmag};
                    if (diff <= {107'd0, tol_r}) begin
                        r.y = to_signed56(tneg, tmag);
                        r.st = ST_OK;
                        done = 1'b1;
                    end
                end
                have_prev = 1'b1;
                pmag = tmag;
                pneg = tneg;
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sender: a stalled transaction holds; a new one follows its gap.
    always @(posedge i_clk) begin
        t_mapped pred;
        t_point  nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                map_point('{i_func, i_x_in, i_y_in}, pred);
                expected_q.insert(expected_q.size(), pred);
                items_sent++;
            end
            if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                i_valid <= 1'b0;
            end else if (point_q.size() != 0) begin
                nxt = point_q.pop_front();
                i_func <= nxt.func;
                i_x_in <= nxt.x;
                i_y_in <= nxt.y;
                i_valid <= 1'b1;
                gap_cnt <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic report(input string what, input logic [55:0] got, input logic [55:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Receiver: checks each result transaction and draws its stall pattern.
    always @(posedge i_clk) begin
        t_mapped want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                status_seen[o_status]++;
                if (expected_q.size() == 0) begin
                    report("unexpected result", o_y_out, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_x_out !== want.x) report("x_out", o_x_out, want.x);
                    if (o_y_out !== want.y) report("y_out", o_y_out, want.y);
                    if (o_status !== want.st)
                        report("status", 56'(o_status), 56'(want.st));
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                i_stall <= 1'b1;
            end else begin
                stall_cnt <= pick_gap();
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_COEF: coef_r = data[47:0];
            CFG_TOL:  tol_r = data[20:0];
            CFG_LIM:  bound_r = data[54:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [47:0] k, input logic [20:0] tol,
                            input logic [54:0] bound);
        cfg_write(CFG_COEF, {7'd0, k});
        cfg_write(CFG_TOL, {34'd0, tol});
        cfg_write(CFG_LIM, bound);
    endtask

    task automatic wait_idle();
        while (point_q.size() != 0 || i_valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [55:0] rand56();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[55:0];
    endfunction

    function automatic logic [55:0] rand_y();
        logic [55:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = rand56() >> 13;
            6, 7:             v = rand56() >> 9;
            8:                return rand56();
            default: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return POS_LIM;
                    2: return NEG_LIM;
                    default: v = ONE_Y;
                endcase
            end
        endcase
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic add_point(input logic func, input logic [55:0] x, input logic [55:0] y);
        point_q.insert(point_q.size(), '{func, x, y});
    endtask

    task automatic add_random(input int n);
        repeat (n) add_point(1'($urandom_range(0, 1)), rand56(), rand_y());
    endtask

    function automatic logic [47:0] small_coef(logic neg);
        logic [47:0] k;
        k = 48'(rand56() >> 22);
        return neg ? -k : k;
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings: k = 0, so the inverse settles on its second step.
        add_point(1'b1, 56'd5, ONE_Y);
        add_point(1'b1, POS_LIM, -ONE_Y);
        add_point(1'b0, NEG_LIM, 56'd0);
        add_point(1'b1, '0, 56'd0);
        add_point(1'b1, '1, POS_LIM);
        add_point(1'b1, 56'h55_AAAA_5555_AAAA, NEG_LIM);
        add_point(1'b0, 56'hAA_5555_AAAA_5555, POS_LIM);
        add_point(1'b0, 56'd7, NEG_LIM);
        add_random(30);
        wait_idle();

        // k = -1.0: zero denominator, saturation, divergence and an exhausted budget.
        set_regs(-(48'd1 << 40), 21'd0, 55'd43980465111040);
        add_point(1'b0, '0, ONE_Y);
        add_point(1'b0, '0, -ONE_Y);
        add_point(1'b0, '0, POS_LIM);
        add_point(1'b0, '0, NEG_LIM);
        add_point(1'b0, '0, ONE_Y << 3);
        add_point(1'b1, '0, ONE_Y);
        add_point(1'b1, '0, ONE_Y >> 1);
        add_point(1'b1, '0, -(ONE_Y >> 1));
        add_point(1'b1, '0, ONE_Y + 56'd1);
        add_point(1'b1, '0, 56'd1);
        add_random(30);
        wait_idle();

        // Small positive k with the widest bound; the sender drains between halves.
        set_regs(small_coef(1'b0), 21'd110, {55{1'b1}});
        add_random(30);
        wait_idle();
        add_random(30);
        wait_idle();

        // Small negative k, tolerance 2^20, bound zero.
        set_regs(small_coef(1'b1), 21'h10_0000, '0);
        add_random(30);
        wait_idle();

        set_regs(48'h7FFF_FFFF_FFFF, 21'($urandom_range(0, 2000)), 55'(rand56() >> 14));
        add_random(20);
        wait_idle();

        // Most negative k with no idling on either side.
        quiet = 1'b1;
        set_regs(48'h8000_0000_0000, 21'h1F_FFFF, 55'(rand56() >> 12));
        add_random(20);
        wait_idle();

        $display("%0d points mapped under 6 register settings, %0d results checked",
                 items_sent, results_seen);
        $display("status counts: ok %0d, bound %0d, no convergence %0d, zero den %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
